@@ rtl/sct_pkg.sv @@
// sct_pkg: shared types, codes and character tables for the source tokenizer
// no dependencies; imported by sct_scan, sct_outq and source_code_tokenizer_core
`default_nettype none

package sct_pkg;

    // tokens produced by one transaction at most
    localparam int MAX_TOKENS = 3;
    typedef logic [1:0] tok_cnt_t;

    // scanner modes
    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_COMMENT = 3'd1;
    localparam logic [2:0] M_WORD    = 3'd2;
    localparam logic [2:0] M_INT     = 3'd3;
    localparam logic [2:0] M_DOT     = 3'd4;
    localparam logic [2:0] M_FRAC    = 3'd5;
    localparam logic [2:0] M_STR     = 3'd6;
    localparam logic [2:0] M_OP      = 3'd7;

    // token kinds
    localparam logic [5:0] K_END    = 6'd0;
    localparam logic [5:0] K_ERR    = 6'd1;
    localparam logic [5:0] K_ID     = 6'd2;
    localparam logic [5:0] K_NUM    = 6'd3;
    localparam logic [5:0] K_STR    = 6'd4;
    localparam logic [5:0] K_KW     = 6'd5;
    localparam logic [5:0] K_DOT    = 6'd33;
    localparam logic [5:0] K_ARROW  = 6'd36;
    localparam logic [5:0] K_NONE   = 6'd0;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CHAR  = 2'd1;
    localparam logic [1:0] ERR_UNTERM = 2'd2;

    // character codes
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_SP    = 8'h20;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_HASH  = 8'h23;
    localparam logic [7:0] C_DOT   = 8'h2E;
    localparam logic [7:0] C_EQ    = 8'h3D;
    localparam logic [7:0] C_GT    = 8'h3E;
    localparam logic [7:0] C_MINUS = 8'h2D;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // first byte of a two-character operator candidate
    function automatic logic is_op(input logic [7:0] c);
        logic r;
        case (c) inside
            8'h2D, 8'h2B, 8'h2F, 8'h25, 8'h2A, 8'h5E, 8'h21, 8'h3D, 8'h3C, 8'h3E: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // single-character punctuators, K_NONE if not one
    function automatic logic [5:0] punct_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            8'h28: k = 6'd25;
            8'h29: k = 6'd26;
            8'h7B: k = 6'd27;
            8'h7D: k = 6'd28;
            8'h3F: k = 6'd29;
            8'h3A: k = 6'd30;
            8'h3B: k = 6'd31;
            8'h2C: k = 6'd32;
            8'h2E: k = K_DOT;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // operator alone, K_NONE for a lone bang
    function automatic logic [5:0] op_alone(input logic [7:0] p);
        logic [5:0] k;
        case (p)
            8'h2D: k = 6'd34;
            8'h2B: k = 6'd37;
            8'h2F: k = 6'd39;
            8'h25: k = 6'd41;
            8'h2A: k = 6'd43;
            8'h5E: k = 6'd45;
            8'h3D: k = 6'd48;
            8'h3C: k = 6'd50;
            8'h3E: k = 6'd52;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // operator followed by '='
    function automatic logic [5:0] op_with_eq(input logic [7:0] p);
        logic [5:0] k;
        case (p)
            8'h2D: k = 6'd35;
            8'h2B: k = 6'd38;
            8'h2F: k = 6'd40;
            8'h25: k = 6'd42;
            8'h2A: k = 6'd44;
            8'h5E: k = 6'd46;
            8'h21: k = 6'd47;
            8'h3D: k = 6'd49;
            8'h3C: k = 6'd51;
            default: k = 6'd53;
        endcase
        return k;
    endfunction

    // keyword match on the zero-padded prefix, first byte in bits 7:0
    function automatic logic [5:0] kw_lookup(input logic [47:0] pf);
        logic [5:0] k;
        case (pf)
            48'h000000646E61: k = K_KW + 6'd0;   // and
            48'h006B61657262: k = K_KW + 6'd1;   // break
            48'h007373616C63: k = K_KW + 6'd2;   // class
            48'h000065736C65: k = K_KW + 6'd3;   // else
            48'h0065736C6166: k = K_KW + 6'd4;   // false
            48'h000000006E66: k = K_KW + 6'd5;   // fn
            48'h000000726F66: k = K_KW + 6'd6;   // for
            48'h000000006669: k = K_KW + 6'd7;   // if
            48'h00007478656E: k = K_KW + 6'd8;   // next
            48'h000000746F6E: k = K_KW + 6'd9;   // not
            48'h00006C6C756E: k = K_KW + 6'd10;  // null
            48'h00000000726F: k = K_KW + 6'd11;  // or
            48'h6E7275746572: k = K_KW + 6'd12;  // return
            48'h007265707573: k = K_KW + 6'd13;  // super
            48'h686374697773: k = K_KW + 6'd14;  // switch
            48'h000073696874: k = K_KW + 6'd15;  // this
            48'h000065757274: k = K_KW + 6'd16;  // true
            48'h000000726176: k = K_KW + 6'd17;  // var
            48'h00006E656877: k = K_KW + 6'd18;  // when
            48'h00656C696877: k = K_KW + 6'd19;  // while
            default:          k = K_ID;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sct_scan.sv @@
// sct_scan: scanner state registers and per-byte token logic
// depends on sct_pkg; produces up to three packed tokens per transaction
`default_nettype none

module sct_scan #(
    parameter int OFFSET_WIDTH = 24,
    parameter int LINE_WIDTH   = 16,
    parameter int TOK_W        = 8 + 2 * OFFSET_WIDTH + 2 * LINE_WIDTH
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  fire,
    input  wire logic                                  kind,
    input  wire logic [7:0]                            ch,
    output logic [sct_pkg::MAX_TOKENS*TOK_W-1:0]       toks,
    output sct_pkg::tok_cnt_t                          tok_cnt
);
    import sct_pkg::*;

    typedef struct packed {
        logic [5:0]              kind;
        logic [1:0]              err;
        logic [OFFSET_WIDTH-1:0] start;
        logic [OFFSET_WIDTH-1:0] len;
        logic [LINE_WIDTH-1:0]   line;
        logic [LINE_WIDTH-1:0]   col;
    } tok_t;

    localparam logic [OFFSET_WIDTH-1:0] OFS_MAX = '1;
    localparam logic [LINE_WIDTH-1:0]   LC_MAX  = '1;

    logic [2:0]              mode_reg, mode_next;
    logic [7:0]              pend_reg, pend_next;
    logic [47:0]             prefix_reg, prefix_next;
    logic [OFFSET_WIDTH-1:0] start_reg, start_next;
    logic [OFFSET_WIDTH-1:0] offs_reg, offs_next;
    logic [LINE_WIDTH-1:0]   line_reg, line_next;
    logic [LINE_WIDTH-1:0]   col_reg, col_next;

    tok_t                    tk [MAX_TOKENS];
    tok_cnt_t                n;
    logic                    go_idle;
    logic [OFFSET_WIDTH-1:0] len_cur;
    logic [5:0]              k_op;

    function automatic logic [OFFSET_WIDTH-1:0] inc_o(input logic [OFFSET_WIDTH-1:0] x);
        return (x == OFS_MAX) ? x : x + 1'b1;
    endfunction

    function automatic logic [LINE_WIDTH-1:0] inc_l(input logic [LINE_WIDTH-1:0] x);
        return (x == LC_MAX) ? x : x + 1'b1;
    endfunction

    function automatic tok_t mk(input logic [5:0] k, input logic [1:0] e,
                                input logic [OFFSET_WIDTH-1:0] s,
                                input logic [OFFSET_WIDTH-1:0] len,
                                input logic [LINE_WIDTH-1:0] ln,
                                input logic [LINE_WIDTH-1:0] cl);
        tok_t t;
        t.kind  = k;
        t.err   = e;
        t.start = s;
        t.len   = len;
        t.line  = ln;
        t.col   = cl;
        return t;
    endfunction

    // keywords only for short words while the offset has not saturated
    function automatic logic [5:0] word_kind(input logic [47:0] pf,
                                             input logic [OFFSET_WIDTH-1:0] len,
                                             input logic [OFFSET_WIDTH-1:0] o);
        logic [5:0] k;
        if (o == OFS_MAX || len == '0 || len > OFFSET_WIDTH'(6))
        begin
            k = K_ID;
        end
        else
        begin
            k = kw_lookup(pf);
        end
        return k;
    endfunction

    // next state and tokens for one transaction
    always_comb
    begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        prefix_next = prefix_reg;
        start_next  = start_reg;
        offs_next   = offs_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        n           = '0;
        go_idle     = 1'b0;
        k_op        = K_NONE;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            tk[i] = '0;
        end
        len_cur = offs_reg - start_reg;

        if (kind || ch == C_NUL)
        begin
            // flush any pending token (the number and the held dot in M_DOT), then the end token
            unique case (mode_reg) inside
                M_WORD:
                begin
                    tk[n] = mk(word_kind(prefix_reg, len_cur, offs_reg), ERR_NONE,
                               start_reg, len_cur, line_next, col_next);
                    n = n + 2'd1;
                end
                M_INT, M_FRAC:
                begin
                    tk[n] = mk(K_NUM, ERR_NONE, start_reg, len_cur, line_next, col_next);
                    n = n + 2'd1;
                end
                M_DOT:
                begin
                    tk[n] = mk(K_NUM, ERR_NONE, start_reg, len_cur, line_next, col_next);
                    n = n + 2'd1;
                    start_next = offs_next;
                    offs_next  = inc_o(offs_next);
                    col_next   = inc_l(col_next);
                    tk[n] = mk(K_DOT, ERR_NONE, start_next, offs_next - start_next,
                               line_next, col_next);
                    n = n + 2'd1;
                end
                M_STR:
                begin
                    tk[n] = mk(K_ERR, ERR_UNTERM, start_reg, len_cur, line_next, col_next);
                    n = n + 2'd1;
                end
                M_OP:
                begin
                    k_op = op_alone(pend_reg);
                    if (k_op == K_NONE)
                    begin
                        tk[n] = mk(K_ERR, ERR_CHAR, start_reg, len_cur, line_next, col_next);
                    end
                    else
                    begin
                        tk[n] = mk(k_op, ERR_NONE, start_reg, len_cur, line_next, col_next);
                    end
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            mode_next   = M_IDLE;
            pend_next   = '0;
            prefix_next = '0;
            start_next  = offs_next;
            tk[n] = mk(K_END, ERR_NONE, offs_next, '0, line_next, col_next);
            n = n + 2'd1;
        end
        else
        begin
            unique case (mode_reg) inside
                M_COMMENT:
                begin
                    if (ch == C_LF)
                    begin
                        go_idle = 1'b1;
                    end
                    else
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                    end
                end
                M_WORD:
                begin
                    if (is_alpha(ch) || is_digit(ch))
                    begin
                        for (int b = 0; b < 6; b++)
                        begin
                            if (len_cur == OFFSET_WIDTH'(b))
                            begin
                                prefix_next[8*b +: 8] = ch;
                            end
                        end
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                    end
                    else
                    begin
                        tk[n] = mk(word_kind(prefix_reg, len_cur, offs_reg), ERR_NONE,
                                   start_reg, len_cur, line_next, col_next);
                        n = n + 2'd1;
                        prefix_next = '0;
                        go_idle     = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (is_digit(ch))
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                    end
                    else if (ch == C_DOT)
                    begin
                        mode_next = M_DOT;
                    end
                    else
                    begin
                        tk[n] = mk(K_NUM, ERR_NONE, start_reg, len_cur, line_next, col_next);
                        n = n + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(ch))
                    begin
                        offs_next = inc_o(inc_o(offs_next));
                        col_next  = inc_l(inc_l(col_next));
                        mode_next = M_FRAC;
                    end
                    else
                    begin
                        // number, then the held dot as its own token
                        tk[n] = mk(K_NUM, ERR_NONE, start_reg, len_cur, line_next, col_next);
                        n = n + 2'd1;
                        start_next = offs_next;
                        offs_next  = inc_o(offs_next);
                        col_next   = inc_l(col_next);
                        tk[n] = mk(K_DOT, ERR_NONE, start_next, offs_next - start_next,
                                   line_next, col_next);
                        n = n + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(ch))
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                    end
                    else
                    begin
                        tk[n] = mk(K_NUM, ERR_NONE, start_reg, len_cur, line_next, col_next);
                        n = n + 2'd1;
                        go_idle = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (ch == C_QUOTE)
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                        tk[n] = mk(K_STR, ERR_NONE, start_reg, offs_next - start_reg,
                                   line_next, col_next);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        if (ch == C_LF)
                        begin
                            line_next = inc_l(line_next);
                            col_next  = '0;
                        end
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                    end
                end
                M_OP:
                begin
                    if (ch == C_EQ || (ch == C_GT && pend_reg == C_MINUS))
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                        k_op = (ch == C_EQ) ? op_with_eq(pend_reg) : K_ARROW;
                        tk[n] = mk(k_op, ERR_NONE, start_reg, offs_next - start_reg,
                                   line_next, col_next);
                        n = n + 2'd1;
                        pend_next = '0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        k_op = op_alone(pend_reg);
                        if (k_op == K_NONE)
                        begin
                            tk[n] = mk(K_ERR, ERR_CHAR, start_reg, len_cur, line_next, col_next);
                        end
                        else
                        begin
                            tk[n] = mk(k_op, ERR_NONE, start_reg, len_cur, line_next, col_next);
                        end
                        n = n + 2'd1;
                        pend_next = '0;
                        go_idle   = 1'b1;
                    end
                end
                default:
                begin
                    go_idle = 1'b1;
                end
            endcase

            // fresh scan of the byte between tokens
            if (go_idle)
            begin
                mode_next = M_IDLE;
                case (ch) inside
                    C_SP, C_CR, C_TAB:
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                    end
                    C_LF:
                    begin
                        line_next = inc_l(line_next);
                        offs_next = inc_o(offs_next);
                        col_next  = '0;
                    end
                    C_HASH:
                    begin
                        offs_next = inc_o(offs_next);
                        col_next  = inc_l(col_next);
                        mode_next = M_COMMENT;
                    end
                    default:
                    begin
                        start_next = offs_next;
                        offs_next  = inc_o(offs_next);
                        col_next   = inc_l(col_next);
                        if (is_alpha(ch))
                        begin
                            prefix_next = {40'd0, ch};
                            mode_next   = M_WORD;
                        end
                        else if (is_digit(ch))
                        begin
                            mode_next = M_INT;
                        end
                        else if (punct_kind(ch) != K_NONE)
                        begin
                            tk[n] = mk(punct_kind(ch), ERR_NONE, start_next,
                                       offs_next - start_next, line_next, col_next);
                            n = n + 2'd1;
                        end
                        else if (ch == C_QUOTE)
                        begin
                            mode_next = M_STR;
                        end
                        else if (is_op(ch))
                        begin
                            pend_next = ch;
                            mode_next = M_OP;
                        end
                        else
                        begin
                            tk[n] = mk(K_ERR, ERR_CHAR, start_next, offs_next - start_next,
                                       line_next, col_next);
                            n = n + 2'd1;
                        end
                    end
                endcase
            end
        end
    end

    // pack tokens for the queue
    always_comb
    begin
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            toks[i*TOK_W +: TOK_W] = TOK_W'(tk[i]);
        end
        tok_cnt = n;
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            pend_reg   <= '0;
            prefix_reg <= '0;
            start_reg  <= '0;
            offs_reg   <= '0;
            line_reg   <= LINE_WIDTH'(1);
            col_reg    <= '0;
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            prefix_reg <= prefix_next;
            start_reg  <= start_next;
            offs_reg   <= offs_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
        end
    end

    // line count never drops to zero
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0) else $error("line count is zero");

    // start of a token never runs past the offset
    a_start_le_offs: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg <= offs_reg) else $error("token start beyond offset");

    // end of source always leaves the scanner idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (kind || ch == C_NUL) |=> mode_reg == M_IDLE)
        else $error("scanner not idle after end of source");

endmodule

`default_nettype wire

@@ rtl/sct_outq.sv @@
// sct_outq: two-entry queue of token groups, serialized one token per cycle while out_ready is high
// depends on sct_pkg; fed by sct_scan, drives the result channel
`default_nettype none

module sct_outq #(
    parameter int TOK_W = 88
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              push,
    input  wire logic [sct_pkg::MAX_TOKENS*TOK_W-1:0] grp,
    input  wire sct_pkg::tok_cnt_t                 grp_cnt,
    output logic                                   has_room,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [TOK_W-1:0]                       out_tok,
    output logic                                   out_last
);
    import sct_pkg::*;

    logic [MAX_TOKENS*TOK_W-1:0] grp_reg [2];
    tok_cnt_t                    cnt_reg [2];
    logic                        wr_reg, wr_next;
    logic                        rd_reg, rd_next;
    logic [1:0]                  fill_reg, fill_next;
    tok_cnt_t                    idx_reg, idx_next;
    logic                        do_push;
    logic                        do_pop;
    tok_cnt_t                    head_cnt;

    assign do_push   = push && grp_cnt != '0;
    assign has_room  = fill_reg != 2'd2;
    assign out_valid = fill_reg != 2'd0;
    assign head_cnt  = cnt_reg[rd_reg];
    assign out_last  = idx_reg == head_cnt - 2'd1;
    assign do_pop    = out_valid && out_ready && out_last;

    // select the current token of the head group
    always_comb
    begin
        case (idx_reg)
            2'd0:    out_tok = grp_reg[rd_reg][0 +: TOK_W];
            2'd1:    out_tok = grp_reg[rd_reg][TOK_W +: TOK_W];
            default: out_tok = grp_reg[rd_reg][2*TOK_W +: TOK_W];
        endcase
    end

    // pointers, fill count and token index
    always_comb
    begin
        wr_next   = do_push ? ~wr_reg : wr_reg;
        rd_next   = do_pop ? ~rd_reg : rd_reg;
        fill_next = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
        idx_next  = idx_reg;
        if (out_valid && out_ready)
        begin
            idx_next = out_last ? '0 : idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= '0;
            idx_reg  <= '0;
        end
        else
        begin
            wr_reg   <= wr_next;
            rd_reg   <= rd_next;
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
        end
    end

    // group storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            grp_reg[wr_reg] <= grp;
            cnt_reg[wr_reg] <= grp_cnt;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 2'd2) else $error("group queue overflow");

    a_head_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> head_cnt != '0 && idx_reg < head_cnt)
        else $error("token index outside head group");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == 2'd0 && do_push |=> out_valid && idx_reg == '0)
        else $error("pushed group not presented");

endmodule

`default_nettype wire

@@ rtl/source_code_tokenizer_core.sv @@
// source_code_tokenizer_core: byte-stream tokenizer top level
// depends on sct_pkg, sct_scan and sct_outq
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | kind, ch
//   out     | out_valid / out_ready| token_kind, error_code, start_offset,
//           |                      | token_length, line_number, column_number, last
//
// one byte per cycle while in_ready is high: the scanner state updates in the cycle a
// transaction is taken and its tokens (0 to 3) enter a two-group queue; the queue drains
// one token per cycle while out_ready is high, so bytes that give two or three tokens back it up
// in_ready is low only while two token groups are waiting, whatever the cause
// reset: idle scanner, offset 0, line 1, column 0, queue empty
`default_nettype none

module source_code_tokenizer_core #(
    parameter int OFFSET_WIDTH = 24,
    parameter int LINE_WIDTH   = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    kind,
    input  wire logic [7:0]              ch,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [5:0]                   token_kind,
    output logic [1:0]                   error_code,
    output logic [OFFSET_WIDTH-1:0]      start_offset,
    output logic [OFFSET_WIDTH-1:0]      token_length,
    output logic [LINE_WIDTH-1:0]        line_number,
    output logic [LINE_WIDTH-1:0]        column_number,
    output logic                         last
);
    import sct_pkg::*;

    localparam int TOK_W = 8 + 2 * OFFSET_WIDTH + 2 * LINE_WIDTH;

    logic                         fire;
    logic [MAX_TOKENS*TOK_W-1:0]  toks;
    tok_cnt_t                     tok_cnt;
    logic [TOK_W-1:0]             out_tok;

    assign fire = in_valid && in_ready;

    // scanner
    sct_scan #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .LINE_WIDTH   (LINE_WIDTH),
        .TOK_W        (TOK_W)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .kind    (kind),
        .ch      (ch),
        .toks    (toks),
        .tok_cnt (tok_cnt)
    );

    // token queue
    sct_outq #(
        .TOK_W (TOK_W)
    ) u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .grp       (toks),
        .grp_cnt   (tok_cnt),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (out_tok),
        .out_last  (last)
    );

    // unpack the token fields, kind in the top bits
    assign token_kind    = out_tok[TOK_W-1 -: 6];
    assign error_code    = out_tok[TOK_W-7 -: 2];
    assign start_offset  = out_tok[2*OFFSET_WIDTH+2*LINE_WIDTH-1 -: OFFSET_WIDTH];
    assign token_length  = out_tok[OFFSET_WIDTH+2*LINE_WIDTH-1 -: OFFSET_WIDTH];
    assign line_number   = out_tok[2*LINE_WIDTH-1 -: LINE_WIDTH];
    assign column_number = out_tok[LINE_WIDTH-1:0];

endmodule

`default_nettype wire
